[rtl/ald_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ald_pkg;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_CODE    = 2'd1,
		KIND_FRAMING = 2'd2
	} result_kind_t;

	localparam logic [7:0]  LONG_MARK     = 8'h7f;
	localparam logic [26:0] MIN_TOTAL     = 27'd5;
	localparam logic [26:0] MAX_PKT_RESET = 27'd67108864;
	localparam logic [2:0]  SHORT_HDR_LEN = 3'd1;
	localparam logic [2:0]  LONG_HDR_LEN  = 3'd4;
	localparam logic [1:0]  LAST_HDR_POS  = 2'd3;

endpackage

`default_nettype wire

[rtl/abridged_length_deframer.sv]
// Length-prefixed packet splitter for a decrypted byte stream.
// Input stream (s_axis_*): one byte per request, taken when tvalid and tready are high.
// Output stream (m_axis_*): at most one result per input byte. tuser carries the
// result kind (payload byte, error packet code, framing error), tlast marks the
// final result of a packet, and tdata carries the payload byte and the 32-bit
// signed code of a one-word packet.
// Configuration: cfg_wr_en writes cfg_wr_data as the largest total packet length,
// header included. Write it only while the block is idle.
// Path: an accepted byte goes into the input register and is evaluated from there,
// and its result goes into the result register that drives m_axis_*.
// Throughput: one byte per cycle unless the receiver stalls (see Stall); each byte
// only updates the small header and payload counters between the two registers.
// Reset: the limit returns to 2^26 bytes and the block waits for a header.
// After a framing error the block keeps taking bytes but gives no result
// until the next reset.
// Stall: when the receiver holds tready low, the result register holds, the
// input register fills, and then s_axis_tready drops until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module abridged_length_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_wr_en,
	input  wire logic [26:0] cfg_wr_data,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata,   // [7:0] payload_byte, [39:8] error_code
	output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
	output logic             m_axis_tlast    // last_of_packet
);
	import ald_pkg::*;

	logic [26:0]  max_pkt_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	result_kind_t kind_s2;
	logic [7:0]   byte_s2;
	logic         last_s2;
	logic [31:0]  code_s2;
	logic         advance;

	logic [1:0]  hdr_pos_q, hdr_pos_d;
	logic        long_q, long_d;
	logic [23:0] wc_q, wc_d;
	logic [25:0] left_q, left_d;
	logic        err_q, err_d;
	logic [31:0] gather_q, gather_d;
	logic        fatal_q, fatal_d;

	logic         res_valid;
	result_kind_t res_kind;
	logic [7:0]   res_byte;
	logic         res_last;
	logic [31:0]  res_code;
	logic [25:0]  left_dec;
	logic [1:0]   code_pos;
	logic [31:0]  gather_mrg;
	logic         hdr_done;
	logic [23:0]  count;
	logic [2:0]   hdr_len;
	logic [26:0]  total;
	logic         bad_len;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign left_dec   = left_q - 26'd1;
	assign code_pos   = ~left_dec[1:0];
	assign gather_mrg = gather_q | ({24'd0, byte_s1} << {code_pos, 3'b000});
	assign total      = {1'b0, count, 2'b00} + {24'd0, hdr_len};
	assign bad_len    = (total < MIN_TOTAL) || (total > max_pkt_q);

	always_comb begin
		hdr_pos_d = hdr_pos_q;
		long_d    = long_q;
		wc_d      = wc_q;
		left_d    = left_q;
		err_d     = err_q;
		gather_d  = gather_q;
		fatal_d   = fatal_q;
		res_valid = 1'b0;
		res_kind  = KIND_PAYLOAD;
		res_byte  = 8'd0;
		res_last  = 1'b0;
		res_code  = 32'd0;
		hdr_done  = 1'b0;
		count     = 24'd0;
		hdr_len   = SHORT_HDR_LEN;
		if (!fatal_q) begin
			if (left_q != 26'd0) begin
				left_d = left_dec;
				if (err_q) begin
					gather_d = gather_mrg;
					if (left_dec == 26'd0) begin
						err_d     = 1'b0;
						res_valid = 1'b1;
						res_kind  = KIND_CODE;
						res_last  = 1'b1;
						res_code  = gather_mrg;
					end
				end else begin
					res_valid = 1'b1;
					res_byte  = byte_s1;
					res_last  = (left_dec == 26'd0);
				end
			end else if (long_q) begin
				if (hdr_pos_q == LAST_HDR_POS) begin
					count    = {byte_s1, wc_q[15:0]};
					wc_d     = count;
					hdr_len  = LONG_HDR_LEN;
					hdr_done = 1'b1;
				end else begin
					case (hdr_pos_q)
						2'd1:    wc_d = wc_q | {16'd0, byte_s1};
						2'd2:    wc_d = wc_q | {8'd0, byte_s1, 8'd0};
						default: wc_d = wc_q;
					endcase
					hdr_pos_d = hdr_pos_q + 2'd1;
				end
			end else if (byte_s1 == LONG_MARK) begin
				long_d    = 1'b1;
				hdr_pos_d = 2'd1;
				wc_d      = 24'd0;
			end else begin
				// zero and high marks give a zero count, which fails the minimum length as a framing error
				count    = (byte_s1 != 8'd0 && byte_s1 < LONG_MARK) ? {16'd0, byte_s1} : 24'd0;
				hdr_done = 1'b1;
			end

			if (hdr_done) begin
				long_d    = 1'b0;
				hdr_pos_d = 2'd0;
				if (bad_len) begin
					fatal_d   = 1'b1;
					res_valid = 1'b1;
					res_kind  = KIND_FRAMING;
				end else begin
					left_d   = {count, 2'b00};
					err_d    = (count == 24'd1);
					gather_d = 32'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pkt_q <= MAX_PKT_RESET;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			hdr_pos_q <= 2'd0;
			long_q    <= 1'b0;
			wc_q      <= 24'd0;
			left_q    <= 26'd0;
			err_q     <= 1'b0;
			gather_q  <= 32'd0;
			fatal_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_pkt_q <= cfg_wr_data;
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				hdr_pos_q <= hdr_pos_d;
				long_q    <= long_d;
				wc_q      <= wc_d;
				left_q    <= left_d;
				err_q     <= err_d;
				gather_q  <= gather_d;
				fatal_q   <= fatal_d;
				valid_s2  <= res_valid;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
		if (advance) begin
			kind_s2 <= res_kind;
			byte_s2 <= res_byte;
			last_s2 <= res_last;
			code_s2 <= res_code;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {code_s2, byte_s2};
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tlast  = last_s2;

`ifndef SYNTHESIS
	a_fatal_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fatal_q |=> fatal_q)
		else $error("framing error latch cleared without reset");

	a_framing_latches: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && res_kind == KIND_FRAMING) |=> fatal_q)
		else $error("framing error issued without latching");

	a_code_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_CODE) |-> m_axis_tlast)
		else $error("error packet code not marked last");

	a_no_header_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q != 26'd0) |-> !long_q)
		else $error("long header active inside a payload");

	a_err_pkt_short: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> (left_q <= 26'd4))
		else $error("error packet longer than one word");
`endif

endmodule

`default_nettype wire
